>>> src/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and field widths for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned PRIO_W  = 8;

  localparam int unsigned IN_DATA_W  = 56;  // 51 bits of fields, padded to bytes
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 2;

  // command codes carried on in_tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // one task slot as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]    task_id;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] remaining;
    logic [PRIO_W-1:0]  prio;
  } slot_t;

endpackage
`default_nettype wire

>>> src/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a table of task slots, with a sequencer
// that scans the slots through one shared compare unit.
// ----------------------------------------------------------------------------
//
//  channel | ports         | direction | content
//  --------+---------------+-----------+-------------------------------------
//  input   | in_t*         | slave     | load a slot or advance one tick
//  result  | out_t*        | master    | one transaction per tick, none per load
//
// A load is taken while idle, and the block stays ready for the next input.
// A tick first scans the slot memory, read one slot per cycle through its
// registered read port, then updates the winner in S_FIN and posts the
// result in S_OUT.
// Reset (rst_n low, synchronous) clears all slot valid bits and time to zero.
// A stalled result holds in the output register; loads and the scan of the
// next tick go on, only posting a new result waits for the register to drain.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int unsigned NUM_SLOTS = 8,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata, low bit up: slot[3], task_id[8], arrival_time[16],
  // burst_length[16], task_priority[8], zero pad[5]
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [pps_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: command[1] (0 load, 1 tick)
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_tdata, low bit up: running_id[8], tick_time[16], turnaround[16],
  // waiting[16]
  output logic [pps_pkg::OUT_DATA_W-1:0]       out_tdata,
  // out_tuser, low bit up: idle[1], finished[1]
  output logic [pps_pkg::OUT_USER_W-1:0]       out_tuser
);

  localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W = IDX_W + 1;
  // working width for time arithmetic: covers both time and 16-bit fields
  localparam int unsigned TW = (TIME_BITS > pps_pkg::FIELD_W) ? TIME_BITS
                                                              : pps_pkg::FIELD_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_OUT
  } state_t;

  state_t                 state_r;
  logic [NUM_SLOTS-1:0]   valid_r;
  logic [TIME_BITS-1:0]   time_r;

  // scan control
  logic [CNT_W-1:0]       cnt_r;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;

  // best candidate so far
  logic                   found_r;
  pps_pkg::slot_t         best_r;
  logic [IDX_W-1:0]       best_idx_r;

  // completion bookkeeping
  logic                   fin_r;
  logic [TW-1:0]          tat_r;

  // output register
  logic                   out_valid_r;
  logic                   out_idle_r;
  logic                   out_fin_r;
  logic [pps_pkg::ID_W-1:0]    out_id_r;
  logic [pps_pkg::FIELD_W-1:0] out_time_r;
  logic [pps_pkg::FIELD_W-1:0] out_tat_r;
  logic [pps_pkg::FIELD_W-1:0] out_wait_r;

  // input field unpack
  logic [pps_pkg::SLOT_W-1:0]  in_slot;
  pps_pkg::slot_t              in_entry;
  logic                        in_fire;
  logic                        load_ok;

  assign in_slot            = in_tdata[2:0];
  assign in_entry.task_id   = in_tdata[10:3];
  assign in_entry.arrival   = in_tdata[26:11];
  assign in_entry.burst     = in_tdata[42:27];
  assign in_entry.remaining = in_tdata[42:27];
  assign in_entry.prio      = in_tdata[50:43];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign load_ok   = in_fire && (in_tuser == pps_pkg::CMD_LOAD) &&
                     (32'(in_slot) < NUM_SLOTS);

  // memory ports
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  pps_pkg::slot_t        mem_wdata;
  logic                  mem_re;
  pps_pkg::slot_t        mem_rdata;
  pps_pkg::slot_t        best_upd;
  logic                  scan_more;
  logic                  take;
  logic                  out_free;
  logic [TW-1:0]         cur_time;
  logic [TW-1:0]         done_time;

  assign scan_more = (cnt_r < CNT_W'(NUM_SLOTS));
  assign mem_re    = (state_r == S_SCAN) && scan_more;

  always_comb begin
    best_upd           = best_r;
    best_upd.remaining = best_r.remaining - pps_pkg::FIELD_W'(1);
    if (state_r == S_FIN) begin
      mem_we    = found_r;
      mem_waddr = best_idx_r;
      mem_wdata = best_upd;
    end else begin
      mem_we    = load_ok;
      mem_waddr = IDX_W'(in_slot);
      mem_wdata = in_entry;
    end
  end

  pps_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  assign cur_time = TW'(time_r);

  pps_cmp #(
    .TW (TW)
  ) u_cmp (
    .cand_valid (cmp_vld_r && valid_r[cmp_idx_r]),
    .cand       (mem_rdata),
    .cur_time   (cur_time),
    .found      (found_r),
    .best       (best_r),
    .take       (take)
  );

  // completion time saturates at the top of the time range
  assign done_time = (time_r < TIME_MAX) ? (cur_time + TW'(1)) : cur_time;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      // in S_OUT the output register is refilled below instead
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (load_ok) begin
            valid_r[IDX_W'(in_slot)] <= 1'b1;
          end
          if (in_fire && (in_tuser == pps_pkg::CMD_TICK)) begin
            cnt_r     <= '0;
            cmp_vld_r <= 1'b0;
            found_r   <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read of slot cnt issues now, its compare runs next cycle
          cmp_vld_r <= scan_more;
          cmp_idx_r <= cnt_r[IDX_W-1:0];
          if (scan_more) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          if (take) begin
            found_r    <= 1'b1;
            best_r     <= mem_rdata;
            best_idx_r <= cmp_idx_r;
          end
          if (!scan_more) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // winner's remaining service is written back by the memory port
          fin_r   <= found_r && (best_upd.remaining == '0);
          tat_r   <= done_time - TW'(best_r.arrival);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idle_r  <= !found_r;
            out_fin_r   <= fin_r;
            out_id_r    <= found_r ? best_r.task_id : '0;
            out_time_r  <= cur_time[pps_pkg::FIELD_W-1:0];
            out_tat_r   <= fin_r ? tat_r[pps_pkg::FIELD_W-1:0] : '0;
            if (fin_r && (tat_r >= TW'(best_r.burst))) begin
              out_wait_r <= pps_pkg::FIELD_W'(tat_r - TW'(best_r.burst));
            end else begin
              out_wait_r <= '0;
            end
            if (time_r < TIME_MAX) begin
              time_r <= time_r + TIME_BITS'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_wait_r, out_tat_r, out_time_r, out_id_r};
  assign out_tuser  = {out_fin_r, out_idle_r};

endmodule
`default_nettype wire

>>> src/pps_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_slot_mem
// Task slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pps_slot_mem #(
  parameter int unsigned NUM_SLOTS = 8,
  parameter int unsigned IDX_W     = 3
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   waddr,
  input  wire pps_pkg::slot_t     wdata,
  input  wire logic               re,
  input  wire logic [IDX_W-1:0]   raddr,
  output pps_pkg::slot_t          rdata
);

  pps_pkg::slot_t mem [NUM_SLOTS];
  pps_pkg::slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/pps_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_cmp
// Shared candidate compare: is the slot ready, and does it beat the best so far.
// ----------------------------------------------------------------------------
module pps_cmp #(
  parameter int unsigned TW = 16
) (
  input  wire logic            cand_valid,
  input  wire pps_pkg::slot_t  cand,
  input  wire logic [TW-1:0]   cur_time,
  input  wire logic            found,
  input  wire pps_pkg::slot_t  best,
  output logic                 take
);

  logic ready;
  logic better;

  always_comb begin
    ready  = cand_valid && (cand.remaining != '0) &&
             (TW'(cand.arrival) <= cur_time);
    // lower priority number first, then earlier arrival; equal keeps lower slot
    better = (cand.prio < best.prio) ||
             ((cand.prio == best.prio) && (cand.arrival < best.arrival));
    take   = ready && (!found || better);
  end

endmodule
`default_nettype wire
